FILE: rtl/miu_pkg.sv
// Package for the attitude filter update: payload types, sequencer states, shared constants.
package miu_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgIntGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPropGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriod   = 2'd2;

  localparam logic [23:0] IntGainRst  = 24'd3277;
  localparam logic [23:0] PropGainRst = 24'd65536;
  localparam logic [31:0] PeriodRst   = 32'd4294967;

  localparam logic signed [31:0] OneQ30  = 32'sh4000_0000;
  localparam logic signed [63:0] HalfQ30 = 64'sh2000_0000;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
  } miu_in_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } miu_out_t;

  // Request to the shared divider / square root unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] num;
    logic [63:0] den;
  } miu_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
  } miu_div_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StSqA,
    StSqAWait,
    StNormA,
    StNormAWait,
    StMul,
    StNq,
    StSqN,
    StSqNWait,
    StNormQ,
    StNormQWait,
    StOut
  } miu_state_e;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] satsym32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483647) return -64'sd2147483647;
    return v;
  endfunction

endpackage

FILE: rtl/miu_divsqrt.sv
// Shared iterative unit: unsigned 64/64 restoring division or 64-bit integer square root.
module miu_divsqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  miu_pkg::miu_div_req_t req_i,
  output miu_pkg::miu_div_rsp_t rsp_o
);
  import miu_pkg::*;

  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic         sqrt_q, sqrt_d;
  logic [63:0]  x_q, x_d;      // dividend shift / radicand
  logic [64:0]  rem_q, rem_d;  // partial remainder
  logic [63:0]  den_q, den_d;
  logic [63:0]  res_q, res_d;
  logic [65:0]  trial;
  logic [64:0]  rem_sh;

  // One quotient or root bit per cycle
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    den_d  = den_q;
    res_d  = res_q;
    rem_sh = '0;
    trial  = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      sqrt_d = req_i.is_sqrt;
      x_d    = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      res_d  = '0;
      cnt_d  = req_i.is_sqrt ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      if (sqrt_q) begin
        rem_sh = {rem_q[62:0], x_q[63:62]};
        trial  = {1'b0, rem_sh} - {res_q[62:0], 2'b01};
        x_d    = {x_q[61:0], 2'b00};
        if (!trial[65]) begin
          rem_d = trial[64:0];
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          res_d = {res_q[62:0], 1'b0};
        end
      end else begin
        rem_sh = {rem_q[63:0], x_q[63]};
        trial  = {1'b0, rem_sh} - {2'b00, den_q};
        x_d    = {x_q[62:0], 1'b0};
        if (!trial[65]) begin
          rem_d = trial[64:0];
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          res_d = {res_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    x_q    <= x_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    res_q  <= res_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

FILE: rtl/miu_mac.sv
// Shared signed 33x33 multiplier with registered product, used once per sequencer step.
module miu_mac (
  input  logic                clk_i,
  input  logic signed [32:0]  a_i,
  input  logic signed [32:0]  b_i,
  output logic signed [65:0]  p_o
);
  import miu_pkg::*;

  logic signed [65:0] p_q, p_d;

  // Product registered before any use
  always_comb p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/mahony_imu_update.sv
// Top level: attitude filter update sequencer around a shared multiplier and divider.
// Work per sample: two square roots, seven divisions and 50 multiply steps on one shared
//   multiplier, plus control states; the first root and three divisions are skipped
//   when the acceleration is all zero.
// Throughput: one sample at a time; in_stall_o is high from acceptance to output transfer.
// Reset: orientation to identity, integral feedback to zero, registers to defaults.
module mahony_imu_update (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  miu_pkg::miu_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output miu_pkg::miu_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [miu_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [miu_pkg::CfgDataW-1:0]      cfg_data_i
);
  import miu_pkg::*;

  miu_state_e state_q, state_d;

  logic [23:0] ki_q, kp_q;
  logic [31:0] dt_q;
  logic signed [31:0] q_q [4];
  logic signed [31:0] fb_q [3];
  logic signed [63:0] a_q [3];      // raw then normalised accel
  logic signed [63:0] g_q [3];
  logic signed [63:0] w_q [16];     // scratch values
  logic signed [63:0] nq_q [4];
  logic [63:0] s_q;
  logic [63:0] acc_q;
  logic [5:0]  step_q;
  logic [1:0]  k_q;
  logic        out_valid_q;
  miu_out_t    out_q;

  miu_div_req_t dreq;
  miu_div_rsp_t drsp;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [63:0] pr;
  logic signed [63:0] den_num;
  logic        accel_nz;
  logic        accept;
  logic [63:0] accel_sq;
  logic [1:0]  ax_sel;
  logic        ax_upd;
  logic signed [63:0] fb_sum;

  miu_divsqrt u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  miu_mac     u_mac (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));

  // Product index p = 4*i + j (i: q index, j: 0 scratch / 1..3 h axis)
  task automatic nq_accum(input logic [5:0] p, input logic signed [63:0] t);
    logic [1:0] qi, hj;
    qi = p[3:2];
    hj = p[1:0];
    if (hj != 2'd0) begin
      case ({qi, hj})
        4'b00_01: nq_q[1] <= nq_q[1] + t;
        4'b00_10: nq_q[2] <= nq_q[2] + t;
        4'b00_11: nq_q[3] <= nq_q[3] + t;
        4'b01_01: nq_q[0] <= nq_q[0] - t;
        4'b01_10: nq_q[3] <= nq_q[3] + t;
        4'b01_11: nq_q[2] <= nq_q[2] - t;
        4'b10_01: nq_q[3] <= nq_q[3] - t;
        4'b10_10: nq_q[0] <= nq_q[0] - t;
        4'b10_11: nq_q[1] <= nq_q[1] + t;
        4'b11_01: nq_q[2] <= nq_q[2] + t;
        4'b11_10: nq_q[1] <= nq_q[1] - t;
        4'b11_11: nq_q[0] <= nq_q[0] - t;
        default: ;
      endcase
    end
  endtask

  function automatic logic signed [63:0] den_sign(input logic signed [63:0] v,
                                                   input logic [63:0] mag);
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  assign accept   = in_valid_i && !in_stall_o;
  assign accel_nz = (a_q[0] != 0) || (a_q[1] != 0) || (a_q[2] != 0);
  assign pr       = mp[63:0];

  // Squared accel magnitude of the incoming transfer
  assign accel_sq = 64'($unsigned(32'(in_data_i.accel_x) * 32'(in_data_i.accel_x)))
                  + 64'($unsigned(32'(in_data_i.accel_y) * 32'(in_data_i.accel_y)))
                  + 64'($unsigned(32'(in_data_i.accel_z) * 32'(in_data_i.accel_z)));

  // Axis handled by the feedback update steps
  always_comb begin
    ax_upd = 1'b1;
    case (step_q)
      6'd17:   ax_sel = 2'd0;
      6'd20:   ax_sel = 2'd1;
      6'd23:   ax_sel = 2'd2;
      default: begin
        ax_sel = 2'd0;
        ax_upd = 1'b0;
      end
    endcase
  end

  assign fb_sum = sat32(64'(fb_q[ax_sel]) + w_q[14]);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:      if (accept) state_d = StSqA;
      StSqA:       state_d = accel_nz ? StSqAWait : StMul;
      StSqAWait:   if (drsp.done) state_d = StNormA;
      StNormA:     state_d = StNormAWait;
      StNormAWait: if (drsp.done) state_d = (k_q == 2'd2) ? StMul : StNormA;
      StMul:       if (step_q == 6'd49) state_d = StNq;
      StNq:        state_d = StSqN;
      StSqN:       state_d = (acc_q == 64'd0) ? StOut : StSqNWait;
      StSqNWait:   if (drsp.done) state_d = (drsp.res == 64'd0) ? StOut : StNormQ;
      StNormQ:     state_d = StNormQWait;
      StNormQWait: if (drsp.done) state_d = (k_q == 2'd3) ? StOut : StNormQ;
      StOut:       if (!out_valid_q) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  // Divider requests
  always_comb begin
    dreq = '0;
    den_num = '0;
    case (state_q)
      StSqA: begin
        dreq.start   = accel_nz;
        dreq.is_sqrt = 1'b1;
        dreq.num     = acc_q << 30;
      end
      StNormA: begin
        den_num      = a_q[k_q] <<< 45;
        dreq.start   = 1'b1;
        dreq.num     = den_num[63] ? 64'(-den_num) : den_num;
        dreq.den     = s_q;
      end
      StSqN: begin
        dreq.start   = (acc_q != 64'd0);
        dreq.is_sqrt = 1'b1;
        dreq.num     = acc_q;
      end
      StNormQ: begin
        den_num      = nq_q[k_q] <<< 30;
        dreq.start   = 1'b1;
        dreq.num     = den_num[63] ? 64'(-den_num) : den_num;
        dreq.den     = s_q;
      end
      default: dreq = '0;
    endcase
  end

  // Multiplier operand schedule; product appears one step later
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == StMul) begin
      case (step_q)
        6'd0:  begin ma = 33'(q_q[1]); mb = 33'(q_q[3]); end
        6'd1:  begin ma = 33'(q_q[0]); mb = 33'(q_q[2]); end
        6'd2:  begin ma = 33'(q_q[0]); mb = 33'(q_q[1]); end
        6'd3:  begin ma = 33'(q_q[2]); mb = 33'(q_q[3]); end
        6'd4:  begin ma = 33'(q_q[0]); mb = 33'(q_q[0]); end
        6'd5:  begin ma = 33'(q_q[3]); mb = 33'(q_q[3]); end
        // error terms: a_n (Q2.30, fits 33 bits) times v
        6'd7:  begin ma = 33'(a_q[1]); mb = 33'(w_q[2]); end
        6'd8:  begin ma = 33'(a_q[2]); mb = 33'(w_q[1]); end
        6'd9:  begin ma = 33'(a_q[2]); mb = 33'(w_q[0]); end
        6'd10: begin ma = 33'(a_q[0]); mb = 33'(w_q[2]); end
        6'd11: begin ma = 33'(a_q[0]); mb = 33'(w_q[1]); end
        6'd12: begin ma = 33'(a_q[1]); mb = 33'(w_q[0]); end
        // integral and proportional products, per axis; the ki term feeds straight back
        6'd14: begin ma = 33'(w_q[3]); mb = {9'd0, ki_q}; end
        6'd17: begin ma = 33'(w_q[4]); mb = {9'd0, ki_q}; end
        6'd20: begin ma = 33'(w_q[5]); mb = {9'd0, ki_q}; end
        6'd15, 6'd18, 6'd21: begin ma = 33'(pr >>> 30); mb = {1'b0, dt_q}; end
        6'd16: begin ma = 33'(w_q[3]); mb = {9'd0, kp_q}; end
        6'd19: begin ma = 33'(w_q[4]); mb = {9'd0, kp_q}; end
        6'd22: begin ma = 33'(w_q[5]); mb = {9'd0, kp_q}; end
        // half-angle steps
        6'd24: begin ma = 33'(g_q[0]); mb = {1'b0, dt_q}; end
        6'd25: begin ma = 33'(g_q[1]); mb = {1'b0, dt_q}; end
        6'd26: begin ma = 33'(g_q[2]); mb = {1'b0, dt_q}; end
        // squares of the saturated new quaternion
        6'd45: begin ma = 33'(satsym32(nq_q[0])); mb = 33'(satsym32(nq_q[0])); end
        6'd46: begin ma = 33'(satsym32(nq_q[1])); mb = 33'(satsym32(nq_q[1])); end
        6'd47: begin ma = 33'(satsym32(nq_q[2])); mb = 33'(satsym32(nq_q[2])); end
        6'd48: begin ma = 33'(satsym32(nq_q[3])); mb = 33'(satsym32(nq_q[3])); end
        // quaternion products q_i * h_j
        default: begin
          if (step_q >= 6'd28 && step_q <= 6'd43) begin
            ma = 33'(q_q[2'((step_q - 6'd28) >> 2)]);
            mb = 33'(w_q[4'd9 + 4'((step_q - 6'd28) & 6'd3)]);
          end
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (accept) begin
        a_q[0] <= 64'(in_data_i.accel_x);
        a_q[1] <= 64'(in_data_i.accel_y);
        a_q[2] <= 64'(in_data_i.accel_z);
        g_q[0] <= 64'(in_data_i.gyro_x);
        g_q[1] <= 64'(in_data_i.gyro_y);
        g_q[2] <= 64'(in_data_i.gyro_z);
        acc_q  <= accel_sq;
        k_q    <= '0;
        step_q <= '0;
      end
      StSqAWait: if (drsp.done) s_q <= drsp.res;
      StNormAWait: if (drsp.done) begin
        a_q[k_q] <= den_sign(a_q[k_q], drsp.res);
        k_q <= k_q + 2'd1;
      end
      StMul: begin
        step_q <= step_q + 6'd1;
        // w[0..2] = v, w[3..5] = e, w[9] = 0 scratch, w[10..12] = h, w[14] = integral step
        case (step_q)
          6'd1:  w_q[0] <= pr >>> 30;
          6'd2:  w_q[0] <= w_q[0] - (pr >>> 30);
          6'd3:  w_q[1] <= pr >>> 30;
          6'd4:  w_q[1] <= w_q[1] + (pr >>> 30);
          6'd5:  w_q[2] <= (pr >>> 30) - HalfQ30;
          6'd6:  w_q[2] <= w_q[2] + (pr >>> 30);
          6'd8:  w_q[3] <= pr >>> 30;
          6'd9:  w_q[3] <= w_q[3] - (pr >>> 30);
          6'd10: w_q[4] <= pr >>> 30;
          6'd11: w_q[4] <= w_q[4] - (pr >>> 30);
          6'd12: w_q[5] <= pr >>> 30;
          6'd13: begin
            w_q[5] <= w_q[5] - (pr >>> 30);
            w_q[9] <= '0;
          end
          6'd16, 6'd19, 6'd22: w_q[14] <= pr >>> 32;
          6'd17, 6'd20, 6'd23: if (accel_nz) begin
            if (ki_q != 0) begin
              g_q[ax_sel] <= sat32(g_q[ax_sel] + fb_sum + (pr >>> 30));
            end else begin
              g_q[ax_sel] <= sat32(g_q[ax_sel] + (pr >>> 30));
            end
          end
          6'd25: w_q[10] <= sat32(pr >>> 19);
          6'd26: w_q[11] <= sat32(pr >>> 19);
          6'd27: w_q[12] <= sat32(pr >>> 19);
          6'd28: begin
            nq_q[0] <= 64'(q_q[0]);
            nq_q[1] <= 64'(q_q[1]);
            nq_q[2] <= 64'(q_q[2]);
            nq_q[3] <= 64'(q_q[3]);
          end
          6'd46: acc_q <= pr;
          6'd47, 6'd48, 6'd49: acc_q <= acc_q + pr;
          default: ;
        endcase
        // q_i * h_j products, accumulate with the update signs
        if (step_q >= 6'd30 && step_q <= 6'd44)
          nq_accum(step_q - 6'd29, pr >>> 30);
      end
      StNq: begin
        for (int i = 0; i < 4; i++) nq_q[i] <= satsym32(nq_q[i]);
        k_q <= '0;
      end
      StSqNWait: if (drsp.done) s_q <= drsp.res;
      StNormQWait: if (drsp.done) begin
        nq_q[k_q] <= sat32(den_sign(nq_q[k_q], drsp.res));
        k_q <= k_q + 2'd1;
      end
      default: ;
    endcase
  end

  // Control, state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      ki_q        <= IntGainRst;
      kp_q        <= PropGainRst;
      dt_q        <= PeriodRst;
      q_q[0]      <= OneQ30;
      q_q[1]      <= '0;
      q_q[2]      <= '0;
      q_q[3]      <= '0;
      fb_q[0]     <= '0;
      fb_q[1]     <= '0;
      fb_q[2]     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgIntGain:  ki_q <= cfg_data_i[23:0];
          CfgPropGain: kp_q <= cfg_data_i[23:0];
          CfgPeriod:   dt_q <= cfg_data_i;
          default: ;
        endcase
      end
      // integral feedback, updated per axis when the accel is nonzero; cleared instead while the integral gain is zero
      if (state_q == StMul && ax_upd && accel_nz) begin
        fb_q[ax_sel] <= (ki_q != 24'd0) ? 32'(fb_sum) : '0;
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == StOut && !out_valid_q) begin
        out_valid_q <= 1'b1;
        if (s_q == 64'd0 || acc_q == 64'd0) begin
          q_q[0] <= OneQ30; q_q[1] <= '0; q_q[2] <= '0; q_q[3] <= '0;
        end else begin
          for (int i = 0; i < 4; i++) q_q[i] <= nq_q[i][31:0];
        end
      end
    end
  end

  assign out_q.quat_w = q_q[0];
  assign out_q.quat_x = q_q[1];
  assign out_q.quat_y = q_q[2];
  assign out_q.quat_z = q_q[3];
  assign out_data_o   = out_q;
  assign out_valid_o  = out_valid_q;
  assign in_stall_o   = (state_q != StIdle) || out_valid_q;

  // Checks
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o)) else $error("result changed");
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy) else $error("divider restarted");

endmodule
